### rtl/shr_pkg.sv
// ----------------------------------------------------------------------------
// shr_pkg
// Shared types, codes and sizes of the sorted handler registry.
// ----------------------------------------------------------------------------
package shr_pkg;

    // default table size
    localparam int TABLE_DEPTH = 32;

    // field widths
    localparam int KEY_W     = 31;
    localparam int HANDLER_W = 32;
    localparam int VALUE_W   = 16;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 3;

    // stream word widths (padded to whole bytes)
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 88;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // command kinds
    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_REPORT   = 1'b1;

    // error modes
    typedef enum logic [MODE_W-1:0] {
        MODE_QUICK  = 2'd0,
        MODE_CALL   = 2'd1,
        MODE_LOG    = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_REPLACED  = 3'd1,
        STAT_REMOVED   = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_ABSENT    = 3'd4,
        STAT_RECORDED  = 3'd5,
        STAT_CALL      = 3'd6,
        STAT_RESERVED  = 3'd7
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_CMP    = 2'd1,
        ST_DECIDE = 2'd2
    } state_t;

    // one table entry
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [HANDLER_W-1:0] handler;
        logic [VALUE_W-1:0]   last_err;
    } entry_t;

    // update command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
        logic rep;
        logic err_wr;
    } cell_op_t;

endpackage

### rtl/sorted_handler_registry_top.sv
// ----------------------------------------------------------------------------
// sorted_handler_registry_top
// Sorted key table in a row of slot cells with register and report commands.
// ----------------------------------------------------------------------------
// Sequence: an accepted word is taken, compared in every cell, then decided
// and updated, and its result word is registered; the decide step waits while
// a pending result is not taken. A new word is taken only back in idle.
// Reset: the table is empty, the global last error is zero and error_mode
// is 1 (call handler). No clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_handler_registry_top #(
    parameter int TABLE_DEPTH = shr_pkg::TABLE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // obj_key[30:0], handler_id[62:31], err_value[78:63], zero pad
    input  logic [shr_pkg::S_TDATA_W-1:0]     s_tdata,
    // cmd[0]
    input  logic                              s_tuser,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // old_handler[31:0], call_default[32], call_handler[64:33],
    // call_value[80:65], zero pad
    output logic [shr_pkg::M_TDATA_W-1:0]     m_tdata,
    // status[2:0]
    output logic [shr_pkg::STATUS_W-1:0]      m_tuser,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [shr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [shr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [shr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int KW    = shr_pkg::KEY_W;
    localparam int HW    = shr_pkg::HANDLER_W;
    localparam int VW    = shr_pkg::VALUE_W;

    shr_pkg::state_t state_reg, state_next;
    logic [shr_pkg::MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [VW-1:0] glob_err_reg, glob_err_next;

    // captured input word
    logic          cmd_reg;
    logic [KW-1:0] key_reg;
    logic [HW-1:0] hnd_reg;
    logic [VW-1:0] val_reg;

    // result register
    logic                         m_valid_reg, m_valid_next;
    logic [shr_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [HW-1:0]                old_reg, old_next;
    logic                         cdef_reg, cdef_next;
    logic [HW-1:0]                chan_reg, chan_next;
    logic [VW-1:0]                cval_reg, cval_next;

    // cell row
    shr_pkg::entry_t entries [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] after_vec;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [TABLE_DEPTH-1:0] valid_vec;
    shr_pkg::cell_op_t op;
    shr_pkg::entry_t   new_entry;
    logic              cmp_en;
    logic              go;
    logic              found;
    logic [HW-1:0]     match_hnd;
    logic              accept;
    logic              cfg_wr;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == shr_pkg::ST_IDLE);
    assign cmp_en = (state_reg == shr_pkg::ST_CMP);
    assign go = (state_reg == shr_pkg::ST_DECIDE) && (!m_valid_reg || m_tready);

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= shr_pkg::MODE_CALL;
        end
        else if (cfg_wr)
        begin
            mode_reg <= pwdata[shr_pkg::MODE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == 1'b0)
        begin
            prdata[shr_pkg::MODE_W-1:0] = mode_reg;
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tuser;
            key_reg <= s_tdata[KW-1:0];
            hnd_reg <= s_tdata[KW+HW-1:KW];
            val_reg <= s_tdata[KW+HW+VW-1:KW+HW];
        end
    end

    assign new_entry.key      = key_reg;
    assign new_entry.handler  = hnd_reg;
    assign new_entry.last_err = '0;

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            shr_pkg::entry_t left_e;
            shr_pkg::entry_t right_e;
            logic            left_a;

            assign valid_vec[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_a = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = entries[gi-1];
                assign left_a = after_vec[gi-1];
            end

            if (gi == TABLE_DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_next
                assign right_e = entries[gi+1];
            end

            shr_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmp_en      (cmp_en),
                .cmp_key     (key_reg),
                .valid       (valid_vec[gi]),
                .op          (op),
                .new_entry   (new_entry),
                .err_value   (val_reg),
                .left_entry  (left_e),
                .left_after  (left_a),
                .right_entry (right_e),
                .entry       (entries[gi]),
                .after       (after_vec[gi]),
                .eq          (eq_vec[gi])
            );
        end
    endgenerate

    // handler of the matching slot
    always_comb
    begin
        match_hnd = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_hnd = match_hnd | (eq_vec[i] ? entries[i].handler : '0);
        end
    end
    assign found = |eq_vec;

    // decision, table update and result
    always_comb
    begin
        op            = '0;
        count_next    = count_reg;
        glob_err_next = glob_err_reg;
        status_next   = status_reg;
        old_next      = old_reg;
        cdef_next     = cdef_reg;
        chan_next     = chan_reg;
        cval_next     = cval_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        if (go)
        begin
            m_valid_next = 1'b1;
            old_next     = '0;
            cdef_next    = 1'b0;
            chan_next    = '0;
            cval_next    = '0;
            if (cmd_reg == shr_pkg::CMD_REGISTER)
            begin
                if ((hnd_reg != '0) && (count_reg == CNT_W'(TABLE_DEPTH)))
                begin
                    status_next = shr_pkg::STAT_FULL;
                end
                else if (found)
                begin
                    old_next = match_hnd;
                    if (hnd_reg != '0)
                    begin
                        op.rep      = 1'b1;
                        status_next = shr_pkg::STAT_REPLACED;
                    end
                    else
                    begin
                        op.rem      = 1'b1;
                        count_next  = count_reg - CNT_W'(1);
                        status_next = shr_pkg::STAT_REMOVED;
                    end
                end
                else if (hnd_reg == '0)
                begin
                    status_next = shr_pkg::STAT_ABSENT;
                end
                else
                begin
                    op.ins      = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    status_next = shr_pkg::STAT_INSERTED;
                end
            end
            else
            begin
                status_next = shr_pkg::STAT_RECORDED;
                case (mode_reg)
                    shr_pkg::MODE_QUICK:
                    begin
                        glob_err_next = val_reg;
                    end
                    shr_pkg::MODE_CALL:
                    begin
                        status_next = shr_pkg::STAT_CALL;
                        cval_next   = val_reg;
                        cdef_next   = !found;
                        chan_next   = match_hnd;
                    end
                    shr_pkg::MODE_LOG:
                    begin
                        if (found)
                        begin
                            op.err_wr = 1'b1;
                        end
                        else
                        begin
                            glob_err_next = val_reg;
                        end
                    end
                    default:
                    begin
                        status_next = shr_pkg::STAT_RECORDED;
                    end
                endcase
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            shr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = shr_pkg::ST_CMP;
                end
            end
            shr_pkg::ST_CMP:
            begin
                state_next = shr_pkg::ST_DECIDE;
            end
            shr_pkg::ST_DECIDE:
            begin
                if (go)
                begin
                    state_next = shr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = shr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= shr_pkg::ST_IDLE;
            count_reg    <= '0;
            glob_err_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            glob_err_reg <= glob_err_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        old_reg    <= old_next;
        cdef_reg   <= cdef_next;
        chan_reg   <= chan_next;
        cval_reg   <= cval_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, cval_reg, chan_reg, cdef_reg, old_reg};

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shr_pkg::ST_DECIDE) |-> $onehot0(eq_vec))
        else $error("key matched in more than one slot");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == shr_pkg::ST_DECIDE && m_valid_reg && !m_tready)
        |=> (state_reg == shr_pkg::ST_DECIDE))
        else $error("pending result overwritten");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (go && op.ins) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the table");

endmodule

### rtl/shr_cell.sv
// ----------------------------------------------------------------------------
// shr_cell
// One table slot: holds an entry, compares it with the broadcast key and
// shifts to or from its neighbours on insert and remove.
// ----------------------------------------------------------------------------
module shr_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmp_en,
    input  logic [shr_pkg::KEY_W-1:0]    cmp_key,
    input  logic                         valid,
    input  shr_pkg::cell_op_t            op,
    input  shr_pkg::entry_t              new_entry,
    input  logic [shr_pkg::VALUE_W-1:0]  err_value,
    input  shr_pkg::entry_t              left_entry,
    input  logic                         left_after,
    input  shr_pkg::entry_t              right_entry,
    output shr_pkg::entry_t              entry,
    output logic                         after,
    output logic                         eq
);

    shr_pkg::entry_t entry_reg;
    logic            gt_reg;
    logic            eq_reg;

    // compare flags, captured in the cycle after the word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (cmp_en)
        begin
            gt_reg <= valid && (entry_reg.key > cmp_key);
            eq_reg <= valid && (entry_reg.key == cmp_key);
        end
    end

    // slot at or beyond the insert position
    assign after = gt_reg || !valid;

    // entry update
    always_ff @(posedge clk)
    begin
        if (op.ins && after)
        begin
            entry_reg <= left_after ? left_entry : new_entry;
        end
        else if (op.rem && (gt_reg || eq_reg || !valid))
        begin
            entry_reg <= right_entry;
        end
        else
        begin
            if (op.rep && eq_reg)
            begin
                entry_reg.handler <= new_entry.handler;
            end
            if (op.err_wr && eq_reg)
            begin
                entry_reg.last_err <= err_value;
            end
        end
    end

    assign entry = entry_reg;
    assign eq    = eq_reg;

endmodule
